// File: rtl/sem_pkg.sv
// Package for the RGB Sobel edge magnitude block.
// Types, constants and command/status structs shared by controller and datapath.
`default_nettype none
package sem_pkg;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam logic [10:0] WIDTH_RESET = 11'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;
    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam int SQ_ITERS = 11;

    typedef struct packed {
        logic step;
        logic sqrt_start;
        logic sqrt_iter;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic sqrt_last;
    } t_stat;
endpackage
`default_nettype wire

// File: rtl/sem_ctrl.sv
// Controller for the RGB Sobel edge magnitude block.
// Sequences line store update, window shift and square-root iterations; uses sem_pkg.
`default_nettype none
module sem_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_emit,
    input  wire logic          i_out_free,
    output sem_pkg::t_cmd      o_cmd,
    input  wire sem_pkg::t_stat i_stat,
    output logic               o_load_out
);
    import sem_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SQRT = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_ready = 1'b0;
        o_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.step = 1'b1;
                    if (i_emit) begin
                        o_cmd.sqrt_start = 1'b1;
                        n_state = S_SQRT;
                    end
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_iter = 1'b1;
                if (i_stat.sqrt_last) n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_out_free) begin
                    o_load_out = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_load_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load_out |-> r_state == S_WAIT) else $error("load outside wait");
    a_sqrt_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sqrt_start |=> r_state == S_SQRT) else $error("sqrt not started");
endmodule
`default_nettype wire

// File: rtl/sem_dp.sv
// Datapath for the RGB Sobel edge magnitude block.
// Line stores, 3x3 window, counters, gradient and bit-serial rounded root; uses sem_pkg.
`default_nettype none
module sem_dp #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_idx,
    input  wire logic [15:0]    i_cfg_data,
    input  wire logic           i_op,
    input  wire logic [7:0]     i_in_red,
    input  wire logic [7:0]     i_in_green,
    input  wire logic [7:0]     i_in_blue,
    input  wire sem_pkg::t_cmd  i_cmd,
    output sem_pkg::t_stat      o_stat,
    output logic                o_emit,
    output logic [7:0]          o_mag_red,
    output logic [7:0]          o_mag_green,
    output logic [7:0]          o_mag_blue,
    output logic                o_last
);
    import sem_pkg::*;
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);

    logic [10:0] r_width;
    logic [15:0] r_height;
    logic [23:0] r_upper [MAX_WIDTH];
    logic [23:0] r_middle [MAX_WIDTH];
    logic [23:0] r_win [9];
    logic [CW-1:0] r_col;
    logic [15:0] r_row;
    logic [26:0] r_seen;
    logic        r_started;

    logic [CW-1:0] w_eff;
    logic [15:0]   h_eff;
    logic [26:0]   total;
    logic [AW-1:0] pc;
    logic [23:0]   pix, top, mid;
    logic [CW-1:0] col_n;
    logic [AW-1:0] rd_addr;
    logic          frame_rst;
    logic [23:0]   r_top, r_mid;

    always_comb begin
        if (r_width == 11'd0) w_eff = CW'(1);
        else if ({21'd0, r_width} > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
        else w_eff = CW'(r_width);
        h_eff = (r_height == 16'd0) ? 16'd1 : r_height;
    end

    assign total = 27'(w_eff * h_eff);

    assign pc = r_col[AW-1:0];
    assign pix = (!i_op && r_seen < total) ? {i_in_red, i_in_green, i_in_blue} : 24'd0;

    // line store words for the current column are read ahead into registers
    assign frame_rst = !i_rst_n || (i_cfg_we && (i_cfg_idx == REG_WIDTH ||
        i_cfg_idx == REG_HEIGHT)) || i_cmd.clear;

    always_comb begin
        if (frame_rst) rd_addr = '0;
        else if (i_cmd.step && col_n < w_eff) rd_addr = col_n[AW-1:0];
        else if (i_cmd.step) rd_addr = '0;
        else rd_addr = pc;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && rd_addr == pc) begin
            r_top <= mid;
            r_mid <= pix;
        end else begin
            r_top <= r_upper[rd_addr];
            r_mid <= r_middle[rd_addr];
        end
    end
    assign top = r_top;
    assign mid = r_mid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_upper[pc] <= mid;
            r_middle[pc] <= pix;
        end
    end

    assign o_emit = r_seen >= 27'(w_eff) + 27'd1;

    // position and border mask latched at step
    logic [CW-1:0] cpos;
    logic [15:0]   rpos;
    logic [8:0]    ok, r_ok;
    logic          r_lastk;
    always_comb begin
        cpos = (r_col == '0) ? w_eff - CW'(1) : r_col - CW'(1);
        rpos = (r_col == '0) ? r_row - 16'd2 : r_row - 16'd1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ok[i*3+j] = ((i == 0) ? (rpos != 16'd0) :
                             (i == 2) ? ({1'b0, rpos} + 17'd1 < {1'b0, h_eff}) : 1'b1)
                          && ((j == 0) ? (cpos != '0) :
                             (j == 2) ? (cpos + CW'(1) < w_eff) : 1'b1);
            end
        end
    end

    assign col_n = r_col + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || i_cmd.clear) begin
            if (!i_rst_n) begin
                r_width <= WIDTH_RESET;
                r_height <= HEIGHT_RESET;
            end else if (i_cfg_we && i_cfg_idx == REG_WIDTH) begin
                r_width <= i_cfg_data[10:0];
            end else if (i_cfg_we && i_cfg_idx == REG_HEIGHT) begin
                r_height <= i_cfg_data;
            end
            if (frame_rst) begin
                r_col <= '0;
                r_row <= '0;
                r_seen <= '0;
                for (int i = 0; i < 9; i++) r_win[i] <= '0;
            end
        end else if (i_cmd.step) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i*3] <= r_win[i*3+1];
                r_win[i*3+1] <= r_win[i*3+2];
            end
            r_win[2] <= top;
            r_win[5] <= mid;
            r_win[8] <= pix;
            r_seen <= r_seen + 27'd1;
            if (col_n >= w_eff) begin
                r_col <= '0;
                r_row <= r_row + 16'd1;
            end else begin
                r_col <= col_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_ok <= ok;
            r_lastk <= (r_seen - 27'(w_eff) - 27'd1) == total - 27'd1;
        end
    end
    assign o_last = r_lastk;

    // gradients from the shifted window, sampled as radicands once per emitted item
    logic [20:0] sq [3];
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            logic signed [11:0] p [9];
            logic signed [11:0] gx, gy;
            logic signed [23:0] gx2, gy2;
            for (int i = 0; i < 9; i++)
                p[i] = r_ok[i] ? $signed({4'd0, r_win[i][16-8*ch +: 8]}) : 12'sd0;
            gx = -p[0] + p[2] - (p[3] <<< 1) + (p[5] <<< 1) - p[6] + p[8];
            gy = -p[0] - (p[1] <<< 1) - p[2] + p[6] + (p[7] <<< 1) + p[8];
            gx2 = gx * gx;
            gy2 = gy * gy;
            sq[ch] = 21'(gx2 + gy2);
        end
    end

    // started flag: window is valid in the cycle after step
    logic r_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pend <= 1'b0;
        else r_pend <= i_cmd.sqrt_start;
    end
    assign r_started = r_pend;

    // restoring square root, two radicand bits per iteration
    logic [21:0] r_rem [3];
    logic [10:0] r_q [3];
    logic [21:0] r_s [3];
    logic [3:0]  r_it;
    always_ff @(posedge i_clk) begin
        if (r_started) begin
            r_it <= '0;
            for (int ch = 0; ch < 3; ch++) begin
                r_s[ch] <= {1'b0, sq[ch]};
                r_rem[ch] <= '0;
                r_q[ch] <= '0;
            end
        end else if (i_cmd.sqrt_iter) begin
            r_it <= r_it + 4'd1;
            for (int ch = 0; ch < 3; ch++) begin
                logic [21:0] t, tr;
                logic [21:0] sv;
                sv = r_s[ch];
                t = {r_rem[ch][19:0], sv[21:20]};
                tr = t - {9'd0, r_q[ch], 2'b01};
                if (!tr[21]) begin
                    r_rem[ch] <= tr;
                    r_q[ch] <= {r_q[ch][9:0], 1'b1};
                end else begin
                    r_rem[ch] <= t;
                    r_q[ch] <= {r_q[ch][9:0], 1'b0};
                end
                r_s[ch] <= {sv[19:0], 2'b00};
            end
        end
    end
    // 21 bits padded to 22: first iteration consumes top bit pair with a zero
    assign o_stat.sqrt_last = i_cmd.sqrt_iter && !r_started && r_it == 4'(SQ_ITERS - 1);

    logic [7:0] mag [3];
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            logic [11:0] qr;
            qr = {1'b0, r_q[ch]} + ((r_rem[ch] > {11'd0, r_q[ch]}) ? 12'd1 : 12'd0);
            mag[ch] = (qr > 12'd255) ? 8'd255 : qr[7:0];
        end
    end
    assign o_mag_red = mag[0];
    assign o_mag_green = mag[1];
    assign o_mag_blue = mag[2];
endmodule
`default_nettype wire

// File: rtl/sobel_edge_magnitude_rgb.sv
// Top level of the RGB Sobel edge magnitude block.
// Joins sem_ctrl and sem_dp and holds the output register; uses sem_pkg.
// Usage:
//   Input channel i_valid/o_ready carries op and an RGB pixel in raster order.
//   Output channel o_valid/i_ready carries the three magnitudes and the
//   last_of_frame flag. The result for pixel k leaves on input item k+width+1;
//   after a frame send width+1 drain items (op = 1) to flush it.
//   An item that yields no result only steps the window. An item that yields a
//   result steps the window, loads the radicands, runs 11 iterations of the
//   per-channel restoring square-root units, loads the output register and
//   returns to idle; input is held off until it is back in idle. The output
//   register holds a result until taken; when the receiver stalls the next
//   result waits and input is held off.
//   Reset (synchronous, active low) sets width 640, height 480 and clears
//   the frame counters and window; line stores are not cleared. A write to
//   the width or height register restarts the frame. o_valid rises once the
//   output register is loaded.
`default_nettype none
module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_in_red,
    input  wire logic [7:0]  i_in_green,
    input  wire logic [7:0]  i_in_blue,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_red,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_blue,
    output logic             o_last_of_frame
);
    import sem_pkg::*;
    t_cmd  cmd;
    t_stat stat;
    logic emit, load, last;
    logic [7:0] mr, mg, mb;
    logic r_valid;
    logic clr;

    sem_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_emit(emit), .i_out_free(!r_valid || i_ready), .o_cmd(cmd),
        .i_stat(stat), .o_load_out(load)
    );

    t_cmd dcmd;
    always_comb begin
        dcmd = cmd;
        dcmd.clear = clr;
    end

    sem_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_op(i_op), .i_in_red(i_in_red),
        .i_in_green(i_in_green), .i_in_blue(i_in_blue), .i_cmd(dcmd), .o_stat(stat),
        .o_emit(emit), .o_mag_red(mr), .o_mag_green(mg), .o_mag_blue(mb), .o_last(last)
    );

    assign clr = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (load) r_valid <= 1'b1;
        else if (i_ready) r_valid <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (load) begin
            o_out_red <= mr;
            o_out_green <= mg;
            o_out_blue <= mb;
            o_last_of_frame <= last;
        end
    end
    assign o_valid = r_valid;
endmodule
`default_nettype wire
